// ===== rtl/wss_pkg.sv =====
package wss_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam int unsigned RUN_W = 6;
    localparam logic [RUN_W-1:0] MAX_BLANKS = 6'd63;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    // register indexes, byte address is 4*index
    localparam logic [1:0] REG_STRIP_LEADING     = 2'd0;
    localparam logic [1:0] REG_STRIP_TRAILING    = 2'd1;
    localparam logic [1:0] REG_COLLAPSE_INTERIOR = 2'd2;

    typedef enum logic [1:0] {
        MODE_LEAD  = 2'd0,
        MODE_TEXT  = 2'd1,
        MODE_BLANK = 2'd2
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_in;
    } in_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       is_terminator;
        logic       last_of_run;
    } out_t;

    typedef struct packed {
        logic strip_leading;
        logic strip_trailing;
        logic collapse_interior;
    } cfg_t;

    // one queued command: a number of spaces, then a closing character
    typedef struct packed {
        logic [RUN_W-1:0] spaces;
        logic [7:0]       tail_char;
        logic             tail_term;
    } cmd_t;

endpackage

// ===== rtl/whitespace_strip_stream.sv =====
// Strips blanks (space, tab) from a byte stream closed by end items. The front
// end takes one item per cycle unless the queue is full, and classifies it;
// a four-entry command queue feeds the back end, which sends one result per
// cycle unless m_ready holds it. An item that emits only its own character
// gives one result; one that releases a replayed blank run first gives its
// spaces (up to 63), so the output port sets the rate. Registers: 0x0
// strip_leading, 0x4 strip_trailing, 0x8 collapse_interior (bit 0 only).
module whitespace_strip_stream (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wss_pkg::PADDR_W-1:0]   paddr,
    input  logic [wss_pkg::PDATA_W-1:0]   pwdata,
    output logic [wss_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  wss_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output wss_pkg::out_t                 m_data
);

    wss_pkg::cfg_t cfg_reg, cfg_next;
    logic          cfg_write;
    logic [1:0]    reg_index;
    logic          push, pop, q_full, q_valid;
    wss_pkg::cmd_t push_cmd, head_cmd;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (reg_index)
                wss_pkg::REG_STRIP_LEADING:     cfg_next.strip_leading     = pwdata[0];
                wss_pkg::REG_STRIP_TRAILING:    cfg_next.strip_trailing    = pwdata[0];
                wss_pkg::REG_COLLAPSE_INTERIOR: cfg_next.collapse_interior = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            wss_pkg::REG_STRIP_LEADING:
                prdata = {{(wss_pkg::PDATA_W-1){1'b0}}, cfg_reg.strip_leading};
            wss_pkg::REG_STRIP_TRAILING:
                prdata = {{(wss_pkg::PDATA_W-1){1'b0}}, cfg_reg.strip_trailing};
            wss_pkg::REG_COLLAPSE_INTERIOR:
                prdata = {{(wss_pkg::PDATA_W-1){1'b0}}, cfg_reg.collapse_interior};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.strip_leading     <= 1'b1;
            cfg_reg.strip_trailing    <= 1'b1;
            cfg_reg.collapse_interior <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    wss_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    wss_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head_cmd (head_cmd)
    );

    wss_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .head_cmd (head_cmd),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== rtl/wss_front.sv =====
module wss_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  wss_pkg::cfg_t cfg,
    input  logic          s_valid,
    output logic          s_ready,
    input  wss_pkg::in_t  s_data,
    input  logic          q_full,
    output logic          push,
    output wss_pkg::cmd_t push_cmd
);

    wss_pkg::scan_mode_t            mode_reg, mode_next;
    logic [wss_pkg::RUN_W-1:0]      blank_run_reg, blank_run_next;
    logic                           accept;
    logic                           blank;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign blank   = (s_data.char_in == wss_pkg::CH_SPACE) ||
                     (s_data.char_in == wss_pkg::CH_TAB);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= wss_pkg::MODE_LEAD;
            blank_run_reg <= '0;
        end else begin
            mode_reg      <= mode_next;
            blank_run_reg <= blank_run_next;
        end
    end

    always_comb begin
        mode_next          = mode_reg;
        blank_run_next     = blank_run_reg;
        push               = 1'b0;
        push_cmd.spaces    = '0;
        push_cmd.tail_char = s_data.char_in;
        push_cmd.tail_term = 1'b0;
        if (accept) begin
            if (s_data.end_in) begin
                push               = 1'b1;
                push_cmd.tail_char = wss_pkg::CH_NUL;
                push_cmd.tail_term = 1'b1;
                if (mode_reg == wss_pkg::MODE_BLANK && !cfg.strip_trailing) begin
                    push_cmd.spaces = blank_run_reg;
                end
                mode_next      = wss_pkg::MODE_LEAD;
                blank_run_next = '0;
            end else begin
                case (mode_reg)
                    wss_pkg::MODE_TEXT: begin
                        if (blank) begin
                            mode_next      = wss_pkg::MODE_BLANK;
                            blank_run_next = wss_pkg::RUN_W'(1);
                        end else begin
                            push = 1'b1;
                        end
                    end
                    wss_pkg::MODE_BLANK: begin
                        if (blank) begin
                            if (blank_run_reg < wss_pkg::MAX_BLANKS) begin
                                blank_run_next = blank_run_reg + wss_pkg::RUN_W'(1);
                            end
                        end else begin
                            push            = 1'b1;
                            push_cmd.spaces = cfg.collapse_interior ?
                                              wss_pkg::RUN_W'(1) : blank_run_reg;
                            mode_next       = wss_pkg::MODE_TEXT;
                            blank_run_next  = '0;
                        end
                    end
                    default: begin
                        // leading blanks keep their byte when passed through
                        if (blank) begin
                            push = !cfg.strip_leading;
                        end else begin
                            push           = 1'b1;
                            mode_next      = wss_pkg::MODE_TEXT;
                            blank_run_next = '0;
                        end
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/wss_queue.sv =====
module wss_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  wss_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output wss_pkg::cmd_t head_cmd
);

    wss_pkg::cmd_t                  entry_reg [wss_pkg::QUEUE_DEPTH];
    logic [wss_pkg::QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [wss_pkg::QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [wss_pkg::QUEUE_AW:0]     count_reg, count_next;

    assign full     = (count_reg == (wss_pkg::QUEUE_AW+1)'(wss_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + wss_pkg::QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + wss_pkg::QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (wss_pkg::QUEUE_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (wss_pkg::QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (wss_pkg::QUEUE_AW+1)'(wss_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("push into full queue");

endmodule

// ===== rtl/wss_back.sv =====
module wss_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  wss_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output wss_pkg::out_t m_data
);

    logic          active_reg, active_next;
    wss_pkg::cmd_t held_reg, held_next;
    logic          m_valid_reg, m_valid_next;
    wss_pkg::out_t m_data_reg, m_data_next;
    wss_pkg::cmd_t src;
    logic          src_ok;
    logic          out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign src      = active_reg ? held_reg : head_cmd;
    assign src_ok   = active_reg || q_valid;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        active_next  = active_reg;
        held_next    = held_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        pop          = 1'b0;
        if (out_free) begin
            m_valid_next = src_ok;
            if (src_ok) begin
                pop = !active_reg;
                if (src.spaces != '0) begin
                    m_data_next.char_out      = wss_pkg::CH_SPACE;
                    m_data_next.is_terminator = 1'b0;
                    m_data_next.last_of_run   = 1'b0;
                    held_next                 = src;
                    held_next.spaces          = src.spaces - wss_pkg::RUN_W'(1);
                    active_next               = 1'b1;
                end else begin
                    m_data_next.char_out      = src.tail_char;
                    m_data_next.is_terminator = src.tail_term;
                    m_data_next.last_of_run   = 1'b1;
                    active_next               = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg   <= held_next;
        m_data_reg <= m_data_next;
    end

    a_active_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> m_valid_reg)
        else $error("command in progress without pending result");

    a_term_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.is_terminator) |->
        (m_data_reg.last_of_run && m_data_reg.char_out == wss_pkg::CH_NUL))
        else $error("malformed terminator");

    a_space_before_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.last_of_run) |->
        (m_data_reg.char_out == wss_pkg::CH_SPACE && active_reg))
        else $error("non-final result is not a replayed space");

endmodule
